@@ rtl/nearest_return_heading_controller_top_macros.svh @@
`ifndef NEAREST_RETURN_HEADING_CONTROLLER_TOP_MACROS_SVH
`define NEAREST_RETURN_HEADING_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define NRHC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define NRHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/nrhc_pkg.sv @@
package nrhc_pkg;

    localparam int RANGE_W   = 16;
    localparam int ANGLE_W   = 18;
    localparam int STEP_W    = 15;
    localparam int GAIN_W    = 12;
    localparam int DBAND_W   = 17;
    localparam int SPEED_W   = 16;
    localparam int CFG_W     = 18;
    localparam int CFG_IDX_W = 3;
    localparam int GAIN_FRAC = 8;

    typedef logic signed [ANGLE_W-1:0] angle_t;

    localparam angle_t ANG_SAT_HI = 18'sd131071;
    localparam angle_t ANG_SAT_LO = -18'sd131072;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ANG  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_DIST  = 3'd7;

    localparam logic [RANGE_W-1:0]        RST_VALID_LOW  = 16'd0;
    localparam logic [RANGE_W-1:0]        RST_VALID_HIGH = 16'd65535;
    localparam angle_t                    RST_FIRST_ANG  = -18'sd51472;
    localparam logic signed [STEP_W-1:0]  RST_ANG_STEP   = 15'sd0;
    localparam logic [GAIN_W-1:0]         RST_TURN_GAIN  = 12'd307;
    localparam logic [DBAND_W-1:0]        RST_DEADBAND   = 17'd3277;
    localparam logic [SPEED_W-1:0]        RST_CRUISE     = 16'd1792;
    localparam logic [RANGE_W-1:0]        RST_STOP_DIST  = 16'd901;

    typedef struct packed {
        logic [RANGE_W-1:0]       valid_range_low;
        logic [RANGE_W-1:0]       valid_range_high;
        logic signed [ANGLE_W-1:0] first_beam_angle;
        logic signed [STEP_W-1:0] beam_angle_step;
        logic [GAIN_W-1:0]        turn_gain;
        logic [DBAND_W-1:0]       heading_deadband;
        logic [SPEED_W-1:0]       cruise_speed;
        logic [RANGE_W-1:0]       stop_distance;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR_MUL,
        ST_ERR_ADD,
        ST_CMD_MUL,
        ST_CMD_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic sample_en;
        logic err_mul;
        logic err_add;
        logic cmd_mul;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic fin_valid;
        logic stop_clear;
        logic out_free;
    } dp_sts_t;

endpackage

@@ rtl/nrhc_cfg.sv @@
module nrhc_cfg
    import nrhc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_VALID_LOW:  cfg_next.valid_range_low  = cfg_wdata[RANGE_W-1:0];
                CFG_VALID_HIGH: cfg_next.valid_range_high = cfg_wdata[RANGE_W-1:0];
                CFG_FIRST_ANG:  cfg_next.first_beam_angle = $signed(cfg_wdata[ANGLE_W-1:0]);
                CFG_ANG_STEP:   cfg_next.beam_angle_step  = $signed(cfg_wdata[STEP_W-1:0]);
                CFG_TURN_GAIN:  cfg_next.turn_gain        = cfg_wdata[GAIN_W-1:0];
                CFG_DEADBAND:   cfg_next.heading_deadband = cfg_wdata[DBAND_W-1:0];
                CFG_CRUISE:     cfg_next.cruise_speed     = cfg_wdata[SPEED_W-1:0];
                CFG_STOP_DIST:  cfg_next.stop_distance    = cfg_wdata[RANGE_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.valid_range_low  <= RST_VALID_LOW;
            cfg_reg.valid_range_high <= RST_VALID_HIGH;
            cfg_reg.first_beam_angle <= RST_FIRST_ANG;
            cfg_reg.beam_angle_step  <= RST_ANG_STEP;
            cfg_reg.turn_gain        <= RST_TURN_GAIN;
            cfg_reg.heading_deadband <= RST_DEADBAND;
            cfg_reg.cruise_speed     <= RST_CRUISE;
            cfg_reg.stop_distance    <= RST_STOP_DIST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/nrhc_ctrl.sv @@
module nrhc_ctrl
    import nrhc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      mode,
    input  logic      last_beam,
    input  dp_sts_t   sts,
    output logic      in_ready,
    output ctrl_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;

    assign accept = in_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode)
                        state_next = ST_CMD_MUL;
                    else if (last_beam)
                        state_next = ST_ERR_MUL;
                end
            end
            // drop back when the scan held no valid sample
            ST_ERR_MUL: state_next = sts.fin_valid ? ST_ERR_ADD : ST_IDLE;
            ST_ERR_ADD: state_next = sts.stop_clear ? ST_CMD_MUL : ST_IDLE;
            ST_CMD_MUL: state_next = ST_CMD_OUT;
            // hold until the output register frees up
            ST_CMD_OUT: state_next = sts.out_free ? ST_IDLE : ST_CMD_OUT;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.sample_en = accept && !mode;
            end
            ST_ERR_MUL: cmd.err_mul  = 1'b1;
            ST_ERR_ADD: cmd.err_add  = 1'b1;
            ST_CMD_MUL: cmd.cmd_mul  = 1'b1;
            ST_CMD_OUT: cmd.out_load = sts.out_free;
            default:    cmd          = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ rtl/nrhc_dp.sv @@
module nrhc_dp
    import nrhc_pkg::*;
#(
    parameter int MAX_BEAMS = 4096
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    input  cfg_t                cfg,
    input  logic [RANGE_W-1:0]  range_sample,
    input  logic                last_beam,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [SPEED_W-1:0]  forward_speed,
    output logic signed [ANGLE_W-1:0] turn_rate,
    output dp_sts_t             sts
);

    localparam int IDX_W  = $clog2(MAX_BEAMS);
    localparam int PROD_W = STEP_W + IDX_W + 1;
    localparam int SUM_W  = ((PROD_W > ANGLE_W) ? PROD_W : ANGLE_W) + 1;
    localparam int CMD_W  = GAIN_W + 1 + ANGLE_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_BEAMS - 1);

    // scan state
    logic [IDX_W-1:0]   beam_cnt_reg,   beam_cnt_next;
    logic [RANGE_W-1:0] near_range_reg, near_range_next;
    logic [IDX_W-1:0]   near_idx_reg,   near_idx_next;
    logic               any_valid_reg,  any_valid_next;

    // snapshot of a finished scan
    logic [RANGE_W-1:0] fin_range_reg;
    logic [IDX_W-1:0]   fin_idx_reg;
    logic               fin_any_reg;

    logic signed [PROD_W-1:0] err_prod_reg;
    angle_t                   heading_err_reg, heading_err_next;
    logic signed [CMD_W-1:0]  cmd_prod_reg;
    logic                     in_band_reg;

    logic                     out_valid_reg, out_valid_next;
    logic [SPEED_W-1:0]       speed_reg;
    angle_t                   turn_reg;

    logic                     hit;
    logic                     take;
    logic [RANGE_W-1:0]       upd_range;
    logic [IDX_W-1:0]         upd_idx;
    logic                     upd_any;
    logic signed [SUM_W-1:0]  err_sum;
    logic [ANGLE_W-1:0]       err_mag;
    logic signed [CMD_W-1:0]  cmd_shift;
    angle_t                   turn_sat;

    // compare-and-keep on the current beam
    assign hit  = (range_sample > cfg.valid_range_low) &&
                  (range_sample < cfg.valid_range_high);
    assign take = hit && (!any_valid_reg || (range_sample < near_range_reg));
    assign upd_range = take ? range_sample : near_range_reg;
    assign upd_idx   = take ? beam_cnt_reg : near_idx_reg;
    assign upd_any   = any_valid_reg || hit;

    always_comb
    begin
        beam_cnt_next   = beam_cnt_reg;
        near_range_next = near_range_reg;
        near_idx_next   = near_idx_reg;
        any_valid_next  = any_valid_reg;
        if (cmd.sample_en)
        begin
            if (last_beam)
            begin
                beam_cnt_next   = '0;
                near_range_next = '0;
                near_idx_next   = '0;
                any_valid_next  = 1'b0;
            end
            else
            begin
                near_range_next = upd_range;
                near_idx_next   = upd_idx;
                any_valid_next  = upd_any;
                if (beam_cnt_reg != IDX_LAST)
                    beam_cnt_next = beam_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beam_cnt_reg   <= '0;
            near_range_reg <= '0;
            near_idx_reg   <= '0;
            any_valid_reg  <= 1'b0;
            fin_any_reg    <= 1'b0;
        end
        else
        begin
            beam_cnt_reg   <= beam_cnt_next;
            near_range_reg <= near_range_next;
            near_idx_reg   <= near_idx_next;
            any_valid_reg  <= any_valid_next;
            if (cmd.sample_en && last_beam)
                fin_any_reg <= upd_any;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sample_en && last_beam)
        begin
            fin_range_reg <= upd_range;
            fin_idx_reg   <= upd_idx;
        end
    end

    // heading error: step * index, then add and clamp
    always_ff @(posedge clk)
    begin
        if (cmd.err_mul)
            err_prod_reg <= PROD_W'($signed(cfg.beam_angle_step)) *
                            PROD_W'($signed({1'b0, fin_idx_reg}));
    end

    assign err_sum = SUM_W'($signed(cfg.first_beam_angle)) + SUM_W'(err_prod_reg);

    always_comb
    begin
        heading_err_next = heading_err_reg;
        if (cmd.err_add)
        begin
            if (err_sum > SUM_W'(ANG_SAT_HI))
                heading_err_next = ANG_SAT_HI;
            else if (err_sum < SUM_W'(ANG_SAT_LO))
                heading_err_next = ANG_SAT_LO;
            else
                heading_err_next = err_sum[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            heading_err_reg <= '0;
        else
            heading_err_reg <= heading_err_next;
    end

    // command: gain product and deadband test
    assign err_mag = heading_err_reg[ANGLE_W-1] ? ($unsigned(~heading_err_reg) + ANGLE_W'(1))
                                                : $unsigned(heading_err_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.cmd_mul)
        begin
            cmd_prod_reg <= CMD_W'($signed({1'b0, cfg.turn_gain})) * CMD_W'(heading_err_reg);
            in_band_reg  <= err_mag < {1'b0, cfg.heading_deadband};
        end
    end

    // floor divide by 256, then clamp
    assign cmd_shift = cmd_prod_reg >>> GAIN_FRAC;

    always_comb
    begin
        if (cmd_shift > CMD_W'(ANG_SAT_HI))
            turn_sat = ANG_SAT_HI;
        else if (cmd_shift < CMD_W'(ANG_SAT_LO))
            turn_sat = ANG_SAT_LO;
        else
            turn_sat = cmd_shift[ANGLE_W-1:0];
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            speed_reg <= in_band_reg ? cfg.cruise_speed : '0;
            turn_reg  <= in_band_reg ? '0 : turn_sat;
        end
    end

    assign out_valid     = out_valid_reg;
    assign forward_speed = speed_reg;
    assign turn_rate     = turn_reg;

    assign sts.fin_valid  = fin_any_reg;
    assign sts.stop_clear = fin_range_reg > cfg.stop_distance;
    assign sts.out_free   = !out_valid_reg || out_ready;

endmodule

@@ rtl/nearest_return_heading_controller_top.sv @@
// Nearest-return heading controller.
// Input channel (in_valid/in_ready) carries one beat per range sample or
// control tick: mode = 0 is a sample of a scan, last_beam closes the scan;
// mode = 1 is a tick that issues a command from the stored heading error.
// Output channel (out_valid/out_ready) carries forward_speed and turn_rate.
// Config port: cfg_wr_en writes cfg_wdata into register cfg_index at once.
// Throughput: a sample that is not last is taken while the controller idles,
// so a scan streams at one beam per cycle unless a tick or a last beam holds
// the controller busy. A last beam goes on to error multiply and, if the scan
// held a valid sample, error add/clamp; if its nearest return then lies beyond
// stop_distance, it issues a command (gain multiply, output load). A tick goes
// through gain multiply and output load. out_valid rises from the output load,
// which waits for a free output register, after the registered multiplies.
// Reset clears the scan state and the stored heading error and loads the
// register defaults. While the receiver stalls, the result holds in the
// output register and samples keep flowing; a new command waits for it with in_ready low.
`include "nearest_return_heading_controller_top_macros.svh"

module nearest_return_heading_controller_top
    import nrhc_pkg::*;
#(
    parameter int MAX_BEAMS = 4096
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      mode,
    input  logic [RANGE_W-1:0]        range_sample,
    input  logic                      last_beam,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [SPEED_W-1:0]        forward_speed,
    output logic signed [ANGLE_W-1:0] turn_rate,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_wdata
);

    cfg_t      cfg;
    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    nrhc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    nrhc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .mode      (mode),
        .last_beam (last_beam),
        .sts       (sts),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    nrhc_dp #(
        .MAX_BEAMS (MAX_BEAMS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg           (cfg),
        .range_sample  (range_sample),
        .last_beam     (last_beam),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .forward_speed (forward_speed),
        .turn_rate     (turn_rate),
        .sts           (sts)
    );

    `NRHC_ASSERT_NEXT(a_tick_starts_cmd, in_valid && in_ready && mode, cmd.cmd_mul,
        "accepted tick did not start the gain multiply")
    `NRHC_ASSERT_NOW(a_busy_blocks_input, cmd.err_mul || cmd.err_add || cmd.cmd_mul,
        !in_ready, "input taken while a command is in flight")
    `NRHC_ASSERT_NOW(a_load_needs_room, cmd.out_load, sts.out_free,
        "output loaded over an untaken result")
    `NRHC_ASSERT_NEXT(a_load_shows_valid, cmd.out_load, out_valid,
        "loaded result not presented")

endmodule

@@ dv/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nrhc_pkg::*;

    localparam int BEAM_LIMIT    = 4096;
    localparam int IDX_W         = $clog2(BEAM_LIMIT);
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_BEATS   = 195;
    localparam int RANDOM_PHASES = 8;
    localparam int PRINT_CAP     = 100;

    typedef enum logic {
        BEAM_SAMPLE  = 1'b0,
        CONTROL_TICK = 1'b1
    } beat_kind_e;

    typedef struct {
        beat_kind_e         kind;
        logic [RANGE_W-1:0] sample_val;
        logic               is_last;
        int                 gap;
    } beat_t;

    typedef struct {
        logic [SPEED_W-1:0] speed;
        angle_t             turn;
    } steer_cmd_t;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      in_valid     = 1'b0;
    logic                      in_ready;
    logic                      mode         = 1'b0;
    logic [RANGE_W-1:0]        range_sample = '0;
    logic                      last_beam    = 1'b0;
    logic                      out_valid;
    logic                      out_ready    = 1'b0;
    logic [SPEED_W-1:0]        forward_speed;
    logic signed [ANGLE_W-1:0] turn_rate;
    logic                      cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index    = '0;
    logic [CFG_W-1:0]          cfg_wdata    = '0;

    nearest_return_heading_controller_top #(
        .MAX_BEAMS(BEAM_LIMIT)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .range_sample (range_sample),
        .last_beam    (last_beam),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .forward_speed(forward_speed),
        .turn_rate    (turn_rate),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow of the register file and of the scan tracker
    cfg_t               steer_cfg;
    logic [RANGE_W-1:0] nearest_dist;
    logic [IDX_W-1:0]   nearest_idx;
    logic               seen_valid;
    logic [IDX_W-1:0]   beam_pos;
    angle_t             heading_err;

    beat_t      pending_beats[$];
    steer_cmd_t expected_cmds[$];

    int src_gap_max   = 0;
    int src_zero_pct  = 100;
    int rcv_stall_max = 0;
    int rcv_zero_pct  = 100;

    int beats_queued   = 0;
    int beats_accepted = 0;
    int scans_closed   = 0;
    int ticks_seen     = 0;
    int cmds_checked   = 0;
    int mismatch_count = 0;

    beat_t drv_beat;
    int    drv_gap_count = 0;
    int    stall_left    = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    function automatic int draw_wait(input int max_w, input int zero_pct);
        if (max_w == 0 || $urandom_range(99) < zero_pct)
            return 0;
        return $urandom_range(max_w);
    endfunction

    function automatic angle_t clamp_angle(input longint v);
        if (v > longint'(ANG_SAT_HI))
            return ANG_SAT_HI;
        if (v < longint'(ANG_SAT_LO))
            return ANG_SAT_LO;
        return angle_t'(v);
    endfunction

    function automatic steer_cmd_t steer_for(input angle_t err);
        steer_cmd_t cmd;
        longint     e;
        longint     mag;
        longint     prod;
        e   = longint'(err);
        mag = (e < 0) ? -e : e;
        if (mag < longint'(steer_cfg.heading_deadband))
        begin
            cmd.speed = steer_cfg.cruise_speed;
            cmd.turn  = '0;
        end
        else
        begin
            prod      = longint'(steer_cfg.turn_gain) * e;
            cmd.speed = '0;
            // arithmetic shift floors toward minus infinity
            cmd.turn  = clamp_angle(prod >>> GAIN_FRAC);
        end
        return cmd;
    endfunction

    task automatic clear_scan_track();
        nearest_dist = '0;
        nearest_idx  = '0;
        seen_valid   = 1'b0;
        beam_pos     = '0;
    endtask

    // advance the shadow tracker by one accepted beat and queue any command it issues
    task automatic track_beat(input beat_kind_e kind, input logic [RANGE_W-1:0] r,
                              input logic lastf);
        longint aim;
        if (kind == CONTROL_TICK)
        begin
            ticks_seen++;
            expected_cmds.push_back(steer_for(heading_err));
            return;
        end
        if (r > steer_cfg.valid_range_low && r < steer_cfg.valid_range_high)
        begin
            if (!seen_valid || r < nearest_dist)
            begin
                nearest_dist = r;
                nearest_idx  = beam_pos;
            end
            seen_valid = 1'b1;
        end
        if (beam_pos < BEAM_LIMIT - 1)
            beam_pos++;
        if (lastf)
        begin
            scans_closed++;
            if (seen_valid)
            begin
                aim = longint'($signed(steer_cfg.first_beam_angle))
                    + longint'($signed(steer_cfg.beam_angle_step)) * longint'(nearest_idx);
                heading_err = clamp_angle(aim);
                if (nearest_dist > steer_cfg.stop_distance)
                    expected_cmds.push_back(steer_for(heading_err));
            end
            clear_scan_track();
        end
    endtask

    // input driver: wait out each beat's gap, then hold the beat until accepted
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            drv_gap_count = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                track_beat(beat_kind_e'(mode), range_sample, last_beam);
                beats_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_beats.size() != 0 && drv_gap_count < pending_beats[0].gap)
                begin
                    drv_gap_count++;
                    in_valid <= 1'b0;
                end
                else if (pending_beats.size() != 0)
                begin
                    drv_beat = pending_beats.pop_front();
                    mode         <= drv_beat.kind;
                    range_sample <= drv_beat.sample_val;
                    last_beam    <= drv_beat.is_last;
                    in_valid     <= 1'b1;
                    drv_gap_count = 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and receiver stalls
    always @(posedge clk)
    begin
        steer_cmd_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                cmds_checked++;
                if (expected_cmds.size() == 0)
                begin
                    report_mismatch("unexpected command, forward_speed",
                                    longint'(forward_speed), 0);
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (forward_speed !== want.speed)
                        report_mismatch("forward_speed", longint'(forward_speed),
                                        longint'(want.speed));
                    if (turn_rate !== want.turn)
                        report_mismatch("turn_rate", longint'(turn_rate), longint'(want.turn));
                end
                stall_left = draw_wait(rcv_stall_max, rcv_zero_pct);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            out_ready <= (stall_left == 0);
        end
    end

    task automatic push_beat(input beat_kind_e kind, input logic [RANGE_W-1:0] r,
                             input logic lastf);
        beat_t b;
        b.kind       = kind;
        b.sample_val = r;
        b.is_last    = lastf;
        b.gap        = draw_wait(src_gap_max, src_zero_pct);
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    task automatic push_scan(input int vals[$]);
        foreach (vals[i])
            push_beat(BEAM_SAMPLE, RANGE_W'(vals[i]), i == vals.size() - 1);
    endtask

    task automatic push_tick();
        push_beat(CONTROL_TICK, RANGE_W'($urandom), 1'($urandom));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        logic [CFG_W-1:0] word;
        word = CFG_W'(value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= word;
        case (idx)
            CFG_VALID_LOW:  steer_cfg.valid_range_low  = word[RANGE_W-1:0];
            CFG_VALID_HIGH: steer_cfg.valid_range_high = word[RANGE_W-1:0];
            CFG_FIRST_ANG:  steer_cfg.first_beam_angle = word[ANGLE_W-1:0];
            CFG_ANG_STEP:   steer_cfg.beam_angle_step  = word[STEP_W-1:0];
            CFG_TURN_GAIN:  steer_cfg.turn_gain        = word[GAIN_W-1:0];
            CFG_DEADBAND:   steer_cfg.heading_deadband = word[DBAND_W-1:0];
            CFG_CRUISE:     steer_cfg.cruise_speed     = word[SPEED_W-1:0];
            CFG_STOP_DIST:  steer_cfg.stop_distance    = word[RANGE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input int lo, hi, first, step, gain, dband, cruise, stop);
        write_reg(CFG_VALID_LOW, lo);
        write_reg(CFG_VALID_HIGH, hi);
        write_reg(CFG_FIRST_ANG, first);
        write_reg(CFG_ANG_STEP, step);
        write_reg(CFG_TURN_GAIN, gain);
        write_reg(CFG_DEADBAND, dband);
        write_reg(CFG_CRUISE, cruise);
        write_reg(CFG_STOP_DIST, stop);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // a beat that issues nothing can still keep the block busy, so settle after the queues drain
    task automatic wait_idle();
        while (pending_beats.size() != 0 || in_valid || expected_cmds.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_idle_style(input int style);
        case (style % 4)
            0:
            begin
                src_gap_max   = 0;
                src_zero_pct  = 100;
                rcv_stall_max = 0;
                rcv_zero_pct  = 100;
            end
            1:
            begin
                src_gap_max   = 16;
                src_zero_pct  = 50;
                rcv_stall_max = 0;
                rcv_zero_pct  = 100;
            end
            2:
            begin
                src_gap_max   = 3;
                src_zero_pct  = 70;
                rcv_stall_max = 16;
                rcv_zero_pct  = 50;
            end
            default:
            begin
                src_gap_max   = 16;
                src_zero_pct  = 30;
                rcv_stall_max = 16;
                rcv_zero_pct  = 30;
            end
        endcase
    endtask

    function automatic logic [RANGE_W-1:0] pick_range(input logic [RANGE_W-1:0] prev);
        int unsigned lo;
        int unsigned hi;
        lo = steer_cfg.valid_range_low;
        hi = steer_cfg.valid_range_high;
        case ($urandom_range(11))
            0, 1: return RANGE_W'($urandom);
            2:    return prev;
            3:    return RANGE_W'(lo);
            4:    return RANGE_W'(hi);
            5:    return RANGE_W'(lo + 1);
            6:    return RANGE_W'(hi - 1);
            default:
                if (hi > lo + 1)
                    return RANGE_W'($urandom_range(hi - 1, lo + 1));
                else
                    return RANGE_W'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int phase_no);
        int lo;
        int hi;
        int step;
        int stop_at;
        int len;
        int sel;
        logic [RANGE_W-1:0] prev;
        logic [RANGE_W-1:0] r;
        lo   = ($urandom_range(3) == 0) ? 0 : $urandom_range(4000);
        hi   = ($urandom_range(3) == 0) ? 65535 : $urandom_range(65535, 20000);
        if (phase_no == 3)
        begin
            // empty window: scans stay silent, ticks still command
            lo = 40000;
            hi = 40001;
        end
        step = (phase_no % 2 == 0) ? int'($urandom_range(16384)) - 8192
                                   : int'($urandom_range(400)) - 200;
        stop_at = (phase_no == 5) ? 65535 : $urandom_range(3000);
        program_regs(lo, hi, int'($urandom_range(262143)) - 131072, step,
                     $urandom_range(4095),
                     ($urandom_range(4) == 0) ? $urandom_range(131071) : $urandom_range(20000),
                     $urandom_range(65535), stop_at);
        set_idle_style(phase_no);
        sel = beats_queued + PHASE_BEATS;
        while (beats_queued < sel)
        begin
            if ($urandom_range(99) < 12)
            begin
                push_tick();
            end
            else
            begin
                len  = ($urandom_range(15) == 0) ? $urandom_range(300, 25)
                                                 : $urandom_range(24, 1);
                prev = RANGE_W'($urandom);
                for (int j = 0; j < len; j++)
                begin
                    if ($urandom_range(99) < 4)
                        push_tick();
                    r = pick_range(prev);
                    push_beat(BEAM_SAMPLE, r, j == len - 1);
                    prev = r;
                end
            end
        end
    endtask

    initial
    begin
        int scan_vals[$];
        steer_cfg = '{valid_range_low:  RST_VALID_LOW,  valid_range_high: RST_VALID_HIGH,
                      first_beam_angle: RST_FIRST_ANG,  beam_angle_step:  RST_ANG_STEP,
                      turn_gain:        RST_TURN_GAIN,  heading_deadband: RST_DEADBAND,
                      cruise_speed:     RST_CRUISE,     stop_distance:    RST_STOP_DIST};
        clear_scan_track();
        heading_err = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults: window edges, tie, silent scan, ticks
        push_tick();
        scan_vals = '{0, 65535, 5000, 3000, 3000, 7000};
        push_scan(scan_vals);
        scan_vals = '{0, 65535};
        push_scan(scan_vals);
        push_tick();
        wait_idle();

        // inverted window with extreme gain and zero deadband
        program_regs(65535, 0, 131071, 8192, 4095, 0, 65535, 0);
        scan_vals = '{5, 100, 65535};
        push_scan(scan_vals);
        push_tick();
        wait_idle();

        // error and turn saturating high
        program_regs(0, 65535, 131071, 8192, 4095, 0, 65535, 0);
        scan_vals = '{9, 9, 8, 8};
        push_scan(scan_vals);
        push_tick();
        wait_idle();

        // error saturating low, nearest not beyond the stop distance
        program_regs(0, 65535, -131072, -8192, 0, 131071, 0, 65534);
        scan_vals = '{65534, 1};
        push_scan(scan_vals);
        push_tick();
        wait_idle();

        // unit gain: tie keeps the first beam, a tick inside a scan leaves it alone
        program_regs(0, 65535, 0, 100, 256, 0, 65535, 0);
        scan_vals = '{50, 40, 40, 60};
        push_scan(scan_vals);
        push_beat(BEAM_SAMPLE, 16'd4000, 1'b0);
        push_beat(CONTROL_TICK, 16'd1, 1'b1);
        push_beat(BEAM_SAMPLE, 16'd2000, 1'b0);
        push_beat(BEAM_SAMPLE, 16'd3000, 1'b1);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            random_phase(p);
            wait_idle();
        end

        $display("Run covered %0d beats (%0d scans closed, %0d ticks) over %0d register settings",
                 beats_accepted, scans_closed, ticks_seen, RANDOM_PHASES + 5);
        $display("Checked %0d commands, %0d mismatches", cmds_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Timeout: %0d beats accepted, %0d commands still expected",
                 beats_accepted, expected_cmds.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
